// File: design/ssf_pkg.sv
package ssf_pkg;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 5;
    localparam int GAP_W  = 16;
    localparam int HB_W   = 4;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam op_t OP_CLOCK_EDGE  = 3'd0;
    localparam op_t OP_SELECT_EDGE = 3'd1;
    localparam op_t OP_MS_TICK     = 3'd2;
    localparam op_t OP_HOST_WRITE  = 3'd3;
    localparam op_t OP_HOST_POP    = 3'd4;
    localparam op_t OP_HOST_PEEK   = 3'd5;

    localparam logic [2:0] REG_SELECT_ACTIVE_HIGH = 3'd0;
    localparam logic [2:0] REG_CLOCK_PHASE        = 3'd1;
    localparam logic [2:0] REG_CLOCK_POLARITY     = 3'd2;
    localparam logic [2:0] REG_LSB_FIRST          = 3'd3;
    localparam logic [2:0] REG_GAP_LIMIT_MS       = 3'd4;
    localparam logic [2:0] REG_MOSI_PRESENT       = 3'd5;
    localparam logic [2:0] REG_MISO_PRESENT       = 3'd6;
    localparam logic [2:0] REG_SELECT_PRESENT     = 3'd7;

    localparam int BIT_LAST      = 7;
    localparam int HALF_BIT_LAST = 15;

endpackage

// File: design/ssf_if.sv
interface ssf_in_if;
    logic               valid;
    logic               ready;
    ssf_pkg::op_t       operation;
    logic               clock_level;
    logic               mosi_level;
    logic               select_level;
    ssf_pkg::byte_t     tx_byte;

    modport source (output valid, operation, clock_level, mosi_level, select_level, tx_byte,
                    input ready);
    modport sink (input valid, operation, clock_level, mosi_level, select_level, tx_byte,
                  output ready);
endinterface

interface ssf_out_if;
    logic               valid;
    logic               ready;
    logic               miso_level;
    logic               miso_drive;
    ssf_pkg::byte_t     rx_byte;
    ssf_pkg::cnt_t      rx_count;
    ssf_pkg::cnt_t      tx_free;
    logic               rx_lost;
    ssf_pkg::byte_t     resync_count;

    modport source (output valid, miso_level, miso_drive, rx_byte, rx_count, tx_free, rx_lost,
                    resync_count, input ready);
    modport sink (input valid, miso_level, miso_drive, rx_byte, rx_count, tx_free, rx_lost,
                  resync_count, output ready);
endinterface

// File: design/spi_slave_with_fifos_top.sv
// SPI slave (modes 0 to 3, MSB or LSB first) driven by event items: clock edge, select edge,
// millisecond tick, host write, host pop and host peek. Each accepted item yields one status
// item. The RX and TX FIFOs live in two synchronous memories read ahead at the head pointer
// the previous item leaves, with a bypass when that item just wrote the same entry.
// An item is taken every cycle while the status output is not held back by ready; it passes
// the stage 1 register, and its status item becomes valid when the update lands in the output
// register (the head read was issued with the item before). The output register lets a new
// item be accepted while a status item waits. Configuration goes through the APB port at byte
// address 4*index; the block relies on the user to write it only while no item is in flight.
module spi_slave_with_fifos_top #(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ssf_in_if.sink                       in_ch,
    ssf_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssf_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssf_pkg::DATA_W-1:0]   pwdata,
    output logic [ssf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int BW    = ssf_pkg::BYTE_W;
    localparam int GW    = ssf_pkg::GAP_W;
    localparam int HW    = ssf_pkg::HB_W;

    // configuration
    logic          sah_reg, cpha_reg, cpol_reg, lsb_reg;
    logic [GW-1:0] gap_limit_reg;
    logic          mosi_en_reg, miso_en_reg, sel_en_reg;
    logic          cfg_we;
    logic [2:0]    cfg_idx;

    // stage 1 item
    logic               s1_valid_reg;
    ssf_pkg::op_t       s1_op_reg;
    logic               s1_clk_reg, s1_mosi_reg, s1_sel_reg;
    logic [BW-1:0]      s1_txb_reg;

    // block state
    logic [HW-1:0]    hb_reg, hb_next;
    logic [BW-1:0]    rx_shift_reg, rx_shift_next;
    logic [BW-1:0]    tx_shift_reg, tx_shift_next;
    logic [GW-1:0]    gap_reg, gap_next;
    logic [BW-1:0]    resyncs_reg, resyncs_next;
    logic [RX_PW-1:0] rx_head_reg, rx_head_next;
    logic [RX_CW-1:0] rx_fill_reg, rx_fill_next;
    logic [TX_PW-1:0] tx_head_reg, tx_head_next;
    logic [TX_CW-1:0] tx_fill_reg, tx_fill_next;
    logic             lost_reg, lost_next;
    logic             miso_reg, miso_next;
    logic             drive_reg, drive_next;

    // memories
    logic [BW-1:0]    rx_mem [RX_DEPTH];
    logic [BW-1:0]    tx_mem [TX_DEPTH];
    logic [BW-1:0]    rx_rdata_reg, tx_rdata_reg;
    logic             rx_fwd_reg, tx_fwd_reg;
    logic [BW-1:0]    rx_fwd_data_reg, tx_fwd_data_reg;
    logic             rx_we, tx_we;
    logic [RX_PW-1:0] rx_wa;
    logic [TX_PW-1:0] tx_wa;
    logic [BW-1:0]    rx_wd, tx_wd;
    logic [BW-1:0]    rx_head_data, tx_head_data;

    // pointer helpers
    logic [RX_PW-1:0] rx_head_inc, rx_tail;
    logic [TX_PW-1:0] tx_head_inc, tx_tail;
    logic [RX_CW:0]   rx_tail_sum;
    logic [TX_CW:0]   tx_tail_sum;
    logic             rx_full, tx_full;

    // edge processing
    logic          sample;
    logic [HW-1:0] hb_chk;
    logic [2:0]    bitpos, idx3;
    logic [3:0]    idx4;
    logic [BW-1:0] txs;
    logic [BW-1:0] rx_byte_next;
    logic          lost_rep;

    // output register
    logic          out_valid_reg;
    logic          out_miso_reg, out_drive_reg, out_lost_reg;
    logic [BW-1:0] out_rx_byte_reg, out_resync_reg;
    ssf_pkg::cnt_t out_rx_count_reg, out_tx_free_reg;
    logic          fire;

    assign fire        = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || fire;

    // apb
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            ssf_pkg::REG_SELECT_ACTIVE_HIGH: prdata[0] = sah_reg;
            ssf_pkg::REG_CLOCK_PHASE:        prdata[0] = cpha_reg;
            ssf_pkg::REG_CLOCK_POLARITY:     prdata[0] = cpol_reg;
            ssf_pkg::REG_LSB_FIRST:          prdata[0] = lsb_reg;
            ssf_pkg::REG_GAP_LIMIT_MS:       prdata[GW-1:0] = gap_limit_reg;
            ssf_pkg::REG_MOSI_PRESENT:       prdata[0] = mosi_en_reg;
            ssf_pkg::REG_MISO_PRESENT:       prdata[0] = miso_en_reg;
            ssf_pkg::REG_SELECT_PRESENT:     prdata[0] = sel_en_reg;
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sah_reg       <= 1'b0;
            cpha_reg      <= 1'b0;
            cpol_reg      <= 1'b0;
            lsb_reg       <= 1'b0;
            gap_limit_reg <= '0;
            mosi_en_reg   <= 1'b1;
            miso_en_reg   <= 1'b0;
            sel_en_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                ssf_pkg::REG_SELECT_ACTIVE_HIGH: sah_reg       <= pwdata[0];
                ssf_pkg::REG_CLOCK_PHASE:        cpha_reg      <= pwdata[0];
                ssf_pkg::REG_CLOCK_POLARITY:     cpol_reg      <= pwdata[0];
                ssf_pkg::REG_LSB_FIRST:          lsb_reg       <= pwdata[0];
                ssf_pkg::REG_GAP_LIMIT_MS:       gap_limit_reg <= pwdata[GW-1:0];
                ssf_pkg::REG_MOSI_PRESENT:       mosi_en_reg   <= pwdata[0];
                ssf_pkg::REG_MISO_PRESENT:       miso_en_reg   <= pwdata[0];
                ssf_pkg::REG_SELECT_PRESENT:     sel_en_reg    <= pwdata[0];
                default:                         sah_reg       <= sah_reg;
            endcase
        end
    end

    // fifo pointers
    assign rx_full     = (rx_fill_reg == RX_CW'(RX_DEPTH));
    assign tx_full     = (tx_fill_reg == TX_CW'(TX_DEPTH));
    assign rx_head_inc = (rx_head_reg == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + 1'b1;
    assign rx_tail_sum = (RX_CW+1)'(rx_head_reg) + (RX_CW+1)'(rx_fill_reg);
    assign tx_tail_sum = (TX_CW+1)'(tx_head_reg) + (TX_CW+1)'(tx_fill_reg);
    assign rx_tail     = (rx_tail_sum >= (RX_CW+1)'(RX_DEPTH))
                       ? RX_PW'(rx_tail_sum - (RX_CW+1)'(RX_DEPTH)) : RX_PW'(rx_tail_sum);
    assign tx_tail     = (tx_tail_sum >= (TX_CW+1)'(TX_DEPTH))
                       ? TX_PW'(tx_tail_sum - (TX_CW+1)'(TX_DEPTH)) : TX_PW'(tx_tail_sum);

    assign rx_head_data = rx_fwd_reg ? rx_fwd_data_reg : rx_rdata_reg;
    assign tx_head_data = tx_fwd_reg ? tx_fwd_data_reg : tx_rdata_reg;

    assign sample = s1_clk_reg ^ (cpha_reg ^ cpol_reg);

    always_comb
    begin
        hb_next       = hb_reg;
        rx_shift_next = rx_shift_reg;
        tx_shift_next = tx_shift_reg;
        gap_next      = gap_reg;
        resyncs_next  = resyncs_reg;
        rx_head_next  = rx_head_reg;
        rx_fill_next  = rx_fill_reg;
        tx_head_next  = tx_head_reg;
        tx_fill_next  = tx_fill_reg;
        lost_next     = lost_reg;
        miso_next     = miso_reg;
        drive_next    = drive_reg;
        rx_we         = 1'b0;
        rx_wa         = rx_tail;
        rx_wd         = rx_shift_reg;
        tx_we         = 1'b0;
        tx_wa         = tx_tail;
        tx_wd         = s1_txb_reg;
        rx_byte_next  = '0;
        txs           = tx_shift_reg;
        hb_chk        = hb_reg;
        bitpos        = '0;
        idx3          = '0;
        idx4          = '0;
        lost_rep      = lost_reg;
        if (fire)
        begin
            case (s1_op_reg)
                ssf_pkg::OP_CLOCK_EDGE:
                begin
                    if (sel_en_reg && (s1_sel_reg != sah_reg))
                    begin
                        hb_next = '0;
                    end
                    else
                    begin
                        if (hb_reg == '0)
                        begin
                            if (tx_fill_reg != '0)
                            begin
                                txs          = tx_head_data;
                                tx_head_next = tx_head_inc;
                                tx_fill_next = tx_fill_reg - 1'b1;
                            end
                            else
                            begin
                                txs = '0;
                            end
                        end
                        tx_shift_next = txs;
                        if ((hb_reg != '0) && (gap_limit_reg != '0) && (gap_reg > gap_limit_reg))
                        begin
                            hb_chk       = '0;
                            resyncs_next = resyncs_reg + 1'b1;
                        end
                        gap_next = '0;
                        bitpos   = hb_chk[HW-1:1];
                        idx3     = lsb_reg ? bitpos : 3'(ssf_pkg::BIT_LAST) - bitpos;
                        idx4     = {1'b0, idx3};
                        if (sample && mosi_en_reg)
                        begin
                            rx_shift_next[idx3] = s1_mosi_reg;
                        end
                        else if (!sample && miso_en_reg)
                        begin
                            // mode 0/2 preloads the following bit
                            if (!cpha_reg)
                            begin
                                if (lsb_reg)
                                    idx4 = {1'b0, idx3} + 4'd1;
                                else
                                    idx4 = (idx3 == '0) ? 4'd8 : {1'b0, idx3} - 4'd1;
                            end
                            miso_next = idx4[3] ? 1'b0 : txs[idx4[2:0]];
                        end
                        if (hb_chk == HW'(ssf_pkg::HALF_BIT_LAST))
                        begin
                            hb_next = '0;
                            rx_we   = 1'b1;
                            rx_wd   = rx_shift_next;
                            if (rx_full)
                            begin
                                rx_wa        = rx_head_reg;
                                rx_head_next = rx_head_inc;
                                lost_next    = 1'b1;
                            end
                            else
                            begin
                                rx_wa        = rx_tail;
                                rx_fill_next = rx_fill_reg + 1'b1;
                                lost_next    = 1'b0;
                            end
                        end
                        else
                        begin
                            hb_next = hb_chk + 1'b1;
                        end
                    end
                end
                ssf_pkg::OP_SELECT_EDGE:
                begin
                    if (miso_en_reg && sel_en_reg)
                    begin
                        if (s1_sel_reg == sah_reg)
                        begin
                            drive_next = 1'b1;
                            miso_next  = (tx_fill_reg != '0)
                                       ? (lsb_reg ? tx_head_data[0] : tx_head_data[BW-1]) : 1'b0;
                            hb_next    = '0;
                        end
                        else
                        begin
                            drive_next = 1'b0;
                        end
                    end
                end
                ssf_pkg::OP_MS_TICK:
                begin
                    if (gap_reg != '1)
                        gap_next = gap_reg + 1'b1;
                end
                ssf_pkg::OP_HOST_WRITE:
                begin
                    tx_we = 1'b1;
                    if (tx_full)
                    begin
                        tx_wa        = tx_head_reg;
                        tx_head_next = tx_head_inc;
                    end
                    else
                    begin
                        tx_wa        = tx_tail;
                        tx_fill_next = tx_fill_reg + 1'b1;
                    end
                end
                ssf_pkg::OP_HOST_POP:
                begin
                    if (rx_fill_reg != '0)
                    begin
                        rx_byte_next = rx_head_data;
                        rx_head_next = rx_head_inc;
                        rx_fill_next = rx_fill_reg - 1'b1;
                    end
                end
                ssf_pkg::OP_HOST_PEEK:
                begin
                    if (rx_fill_reg != '0)
                        rx_byte_next = rx_head_data;
                end
                default:
                begin
                    hb_next = hb_reg;
                end
            endcase
            lost_rep = lost_next;
            if (s1_op_reg == ssf_pkg::OP_HOST_PEEK)
                lost_next = 1'b0;
        end
    end

    // memories: read at the head the current item leaves behind
    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_mem[rx_wa] <= rx_wd;
        rx_rdata_reg    <= rx_mem[rx_head_next];
        rx_fwd_data_reg <= rx_wd;
        if (tx_we)
            tx_mem[tx_wa] <= tx_wd;
        tx_rdata_reg    <= tx_mem[tx_head_next];
        tx_fwd_data_reg <= tx_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_fwd_reg    <= 1'b0;
            tx_fwd_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hb_reg        <= '0;
            rx_shift_reg  <= '0;
            tx_shift_reg  <= '0;
            gap_reg       <= '0;
            resyncs_reg   <= '0;
            rx_head_reg   <= '0;
            rx_fill_reg   <= '0;
            tx_head_reg   <= '0;
            tx_fill_reg   <= '0;
            lost_reg      <= 1'b0;
            miso_reg      <= 1'b0;
            drive_reg     <= 1'b0;
        end
        else
        begin
            rx_fwd_reg    <= rx_we && (rx_wa == rx_head_next);
            tx_fwd_reg    <= tx_we && (tx_wa == tx_head_next);
            s1_valid_reg  <= in_ch.valid || (s1_valid_reg && !fire);
            out_valid_reg <= fire || (out_valid_reg && !out_ch.ready);
            hb_reg        <= hb_next;
            rx_shift_reg  <= rx_shift_next;
            tx_shift_reg  <= tx_shift_next;
            gap_reg       <= gap_next;
            resyncs_reg   <= resyncs_next;
            rx_head_reg   <= rx_head_next;
            rx_fill_reg   <= rx_fill_next;
            tx_head_reg   <= tx_head_next;
            tx_fill_reg   <= tx_fill_next;
            lost_reg      <= lost_next;
            miso_reg      <= miso_next;
            drive_reg     <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_op_reg   <= in_ch.operation;
            s1_clk_reg  <= in_ch.clock_level;
            s1_mosi_reg <= in_ch.mosi_level;
            s1_sel_reg  <= in_ch.select_level;
            s1_txb_reg  <= in_ch.tx_byte;
        end
        if (fire)
        begin
            out_miso_reg     <= miso_next;
            out_drive_reg    <= drive_next;
            out_rx_byte_reg  <= rx_byte_next;
            out_rx_count_reg <= ssf_pkg::CNT_W'(rx_fill_next);
            out_tx_free_reg  <= ssf_pkg::CNT_W'(TX_CW'(TX_DEPTH) - tx_fill_next);
            out_lost_reg     <= lost_rep;
            out_resync_reg   <= resyncs_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.miso_level   = out_miso_reg;
    assign out_ch.miso_drive   = out_drive_reg;
    assign out_ch.rx_byte      = out_rx_byte_reg;
    assign out_ch.rx_count     = out_rx_count_reg;
    assign out_ch.tx_free      = out_tx_free_reg;
    assign out_ch.rx_lost      = out_lost_reg;
    assign out_ch.resync_count = out_resync_reg;

endmodule
